>>> design/assert_macros.svh
// Assertion macros for the resize query parser; the parse core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion %m failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion %m failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion %m failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/rqp_pkg.sv
// Types, character codes and widths shared by the resize query parser.
`default_nettype none

package rqp_pkg;

    localparam int CHAR_W  = 8;
    localparam int ACC_W   = 17;
    localparam int NAME_W  = 12;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 1;
    localparam int OUT_W   = 56;

    localparam logic [ACC_W-1:0]  ACC_MAX   = '1;
    localparam logic [NAME_W-1:0] NAME_MAX  = '1;
    localparam logic [CFG_W-1:0]  MAX_W_RST = 16'd4096;
    localparam logic [CFG_W-1:0]  MAX_H_RST = 16'd4096;

    localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_W_SEL = 8'h77;
    localparam logic [CHAR_W-1:0] CHAR_H_SEL = 8'h68;
    localparam logic [CHAR_W-1:0] CHAR_AMP   = 8'h26;
    localparam logic [CHAR_W-1:0] CHAR_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_WIDTH  = 1'b0,
        REG_MAX_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_W    = 2'd1,
        SEL_H    = 2'd2
    } t_sel;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_MARK  = 3'd1,
        ST_BAD_CHAR = 3'd2,
        ST_W_RANGE  = 3'd3,
        ST_H_RANGE  = 3'd4
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [NAME_W-1:0] name_length;
        logic [ACC_W-1:0]  height_value;
        logic [ACC_W-1:0]  width_value;
        t_status           status;
    } t_result;

    // Handshake between the parse core and the register stages around it.
    typedef struct packed {
        logic take;       // the held byte is consumed this cycle
        logic load;       // a result is written into the output register
    } t_core_ctl;

endpackage

`default_nettype wire

>>> design/rqp_in_stage.sv
// Input register that holds one received byte until the parse core takes it.
`default_nettype none

module rqp_in_stage
    import rqp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [CHAR_W-1:0] i_char_byte,
    input  wire logic              i_last_byte,
    output logic                   o_ready,
    input  wire t_core_ctl         i_ctl,
    output logic                   o_valid,
    output t_in_item               o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     w_load;

    assign o_ready = !r_valid || i_ctl.take;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ctl.take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.char_byte <= i_char_byte;
            r_item.last_byte <= i_last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> design/rqp_parse.sv
// Parse core: query state registers, limit registers and the result decision.
`default_nettype none

`include "assert_macros.svh"

module rqp_parse
    import rqp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire logic             i_item_valid,
    input  wire t_in_item         i_item,
    input  wire logic             i_out_free,
    output t_core_ctl             o_ctl,
    output t_result               o_result
);

    logic [CFG_W-1:0]  r_max_width;
    logic [CFG_W-1:0]  r_max_height;

    logic              r_after_mark,  n_after_mark;
    t_sel              r_field_select, n_field_select;
    logic              r_bad_seen,    n_bad_seen;
    logic [ACC_W-1:0]  r_width_acc,   n_width_acc;
    logic [ACC_W-1:0]  r_height_acc,  n_height_acc;
    logic [NAME_W-1:0] r_name_count,  n_name_count;

    logic [CHAR_W-1:0] w_c;
    logic              w_is_digit;
    logic [3:0]        w_digit;
    logic [ACC_W-1:0]  w_width_step;
    logic [ACC_W-1:0]  w_height_step;
    logic              w_take;
    logic              w_end;

    // acc * 10 + digit, clamped to the accumulator range.
    function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [3:0] digit);
        logic [ACC_W+3:0] v;
        v = (ACC_W+4)'({acc, 3'b000}) + (ACC_W+4)'({acc, 1'b0}) + (ACC_W+4)'(digit);
        return (v > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
    endfunction

    assign w_c           = i_item.char_byte;
    assign w_is_digit    = (w_c >= CHAR_ZERO) && (w_c <= CHAR_NINE);
    assign w_digit       = 4'(w_c - CHAR_ZERO);
    assign w_width_step  = acc_digit(r_width_acc, w_digit);
    assign w_height_step = acc_digit(r_height_acc, w_digit);

    // A final byte can only be taken when the output register has room.
    assign w_take     = i_item_valid && (!i_item.last_byte || i_out_free);
    assign w_end      = w_take && i_item.last_byte;
    assign o_ctl.take = w_take;
    assign o_ctl.load = w_end;

    always_comb begin
        n_after_mark   = r_after_mark;
        n_field_select = r_field_select;
        n_bad_seen     = r_bad_seen;
        n_width_acc    = r_width_acc;
        n_height_acc   = r_height_acc;
        n_name_count   = r_name_count;
        if (!r_bad_seen) begin
            if (!r_after_mark) begin
                // Name part: count every byte but a zero byte (an error) up to the question mark.
                if (w_c == CHAR_QMARK) begin
                    n_after_mark = 1'b1;
                end else if (w_c == CHAR_NUL) begin
                    n_bad_seen = 1'b1;
                end else if (r_name_count != NAME_MAX) begin
                    n_name_count = r_name_count + 1'b1;
                end
            end else begin
                case (w_c)
                    CHAR_W_SEL: n_field_select = SEL_W;
                    CHAR_H_SEL: n_field_select = SEL_H;
                    CHAR_AMP, CHAR_EQ: ;
                    default: begin
                        if (w_is_digit) begin
                            // Digits without a selector are dropped.
                            case (r_field_select)
                                SEL_W:   n_width_acc  = w_width_step;
                                SEL_H:   n_height_acc = w_height_step;
                                default: ;
                            endcase
                        end else begin
                            n_bad_seen = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.width_value  = n_width_acc;
        o_result.height_value = n_height_acc;
        o_result.name_length  = n_name_count;
        if (!n_after_mark) begin
            o_result.status = ST_NO_MARK;
        end else if (n_bad_seen) begin
            o_result.status = ST_BAD_CHAR;
        end else if ((n_width_acc == '0) || (n_width_acc > ACC_W'(r_max_width))) begin
            o_result.status = ST_W_RANGE;
        end else if ((n_height_acc == '0) || (n_height_acc > ACC_W'(r_max_height))) begin
            o_result.status = ST_H_RANGE;
        end else begin
            o_result.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width  <= MAX_W_RST;
            r_max_height <= MAX_H_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MAX_WIDTH:  r_max_width  <= i_cfg_wdata;
                REG_MAX_HEIGHT: r_max_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_end) begin
            r_after_mark   <= 1'b0;
            r_field_select <= SEL_NONE;
            r_bad_seen     <= 1'b0;
            r_width_acc    <= '0;
            r_height_acc   <= '0;
            r_name_count   <= '0;
        end else if (w_take) begin
            r_after_mark   <= n_after_mark;
            r_field_select <= n_field_select;
            r_bad_seen     <= n_bad_seen;
            r_width_acc    <= n_width_acc;
            r_height_acc   <= n_height_acc;
            r_name_count   <= n_name_count;
        end
    end

    `ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, w_end, !r_after_mark && !r_bad_seen && (r_width_acc == '0) && (r_height_acc == '0) && (r_name_count == '0))
    `ASSERT_NEXT(a_error_freezes, i_clk, i_rst_n, r_bad_seen && !w_end, r_bad_seen && $stable(r_width_acc) && $stable(r_height_acc) && $stable(r_name_count))
    `ASSERT_NEXT(a_name_frozen_after_mark, i_clk, i_rst_n, r_after_mark && !w_end, r_after_mark && $stable(r_name_count))

endmodule

`default_nettype wire

>>> design/rqp_out_stage.sv
// Output register that holds one result until the downstream side takes it.
`default_nettype none

module rqp_out_stage
    import rqp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_core_ctl    i_ctl,
    input  wire t_result      i_result,
    input  wire logic         i_ready,
    output logic              o_free,
    output logic              o_valid,
    output logic [OUT_W-1:0]  o_data
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = OUT_W'(r_result);

endmodule

`default_nettype wire

>>> design/resize_query_parser.sv
// Top level of the resize query parser: byte stream in, one result per request out.
//
// The request string (name?w=X&h=Y) arrives on the slave stream one byte per
// transaction, with tlast on its final byte. Configuration writes set the
// largest accepted width (index 0) and height (index 1); both reset to 4096.
// Both must be written by the user only while no request is in flight (unenforced).
// Each byte is captured in an input register, then parsed from there by the
// core, which updates the name counter, the field selector and the
// decimal accumulators. On the final byte the core writes one result into an
// output register: status, width, height and name length, and the parse
// state returns to its start values for the next request.
// Throughput is one byte per cycle while no final byte waits for the output
// register; the only loop is the accumulator update (multiply by ten, add,
// clamp), which is combinational. The result is registered in the output register.
// When the master side stalls, the held result stays put; bytes that are not
// final keep flowing, and a final byte waits in the input register until the
// output register frees up, which then stalls the slave side.
// Reset is synchronous and active low: it empties both registers, clears the
// parse state and restores the limit registers.
`default_nettype none

module resize_query_parser
    import rqp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Configuration write port.
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    // Slave stream: one request byte per transaction.
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [CHAR_W-1:0] i_s_axis_tdata,   // [7:0] char_byte
    input  wire logic              i_s_axis_tlast,   // last_byte
    // Master stream: one result per request.
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [OUT_W-1:0]       o_m_axis_tdata    // [2:0] status, [19:3] width_value,
                                                     // [36:20] height_value,
                                                     // [48:37] name_length, rest zero
);

    t_core_ctl w_ctl;
    t_in_item  w_item;
    t_result   w_result;
    logic      w_item_valid;
    logic      w_out_free;

    rqp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_char_byte (i_s_axis_tdata),
        .i_last_byte (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .i_ctl       (w_ctl),
        .o_valid     (w_item_valid),
        .o_item      (w_item)
    );

    rqp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .i_out_free   (w_out_free),
        .o_ctl        (w_ctl),
        .o_result     (w_result)
    );

    rqp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_result (w_result),
        .i_ready  (i_m_axis_tready),
        .o_free   (w_out_free),
        .o_valid  (o_m_axis_tvalid),
        .o_data   (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> sim/resize_query_parser_checker.sv
// Result checker for the resize query parser: predicts every result from the byte stream and compares it.
`timescale 1ns / 100ps

module resize_query_parser_checker
    import rqp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tready,
    input  wire logic [CHAR_W-1:0] i_s_tdata,
    input  wire logic              i_s_tlast,
    input  wire logic              i_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [OUT_W-1:0]  i_m_tdata,
    output int                     o_mismatches,
    output int                     o_results_pending,
    output int                     o_results_checked
);

    localparam int RES_W = $bits(t_result);

    // Predicted copy of the limit registers and of the parse state.
    logic [CFG_W-1:0]  limit_w;
    logic [CFG_W-1:0]  limit_h;
    logic              mark_seen;
    t_sel              digit_target;
    logic              error_seen;
    logic [ACC_W-1:0]  width_sum;
    logic [ACC_W-1:0]  height_sum;
    logic [NAME_W-1:0] name_bytes;

    t_result awaited_results[$];
    int      mismatch_total = 0;
    int      checked_total  = 0;

    initial begin
        o_mismatches      = 0;
        o_results_pending = 0;
        o_results_checked = 0;
    end

    function automatic logic [ACC_W-1:0] shift_in_digit(logic [ACC_W-1:0] acc,
                                                        logic [CHAR_W-1:0] c);
        int unsigned v;
        v = int'(acc) * 10 + (int'(c) - int'(CHAR_ZERO));
        return (v > int'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
    endfunction

    task automatic clear_parse();
        mark_seen    = 1'b0;
        digit_target = SEL_NONE;
        error_seen   = 1'b0;
        width_sum    = '0;
        height_sum   = '0;
        name_bytes   = '0;
    endtask

    task automatic take_request_byte(logic [CHAR_W-1:0] c, logic is_final);
        t_result r;
        // Once a bad byte is seen nothing moves until the final byte.
        if (!error_seen) begin
            if (!mark_seen) begin
                if (c == CHAR_QMARK)
                    mark_seen = 1'b1;
                else if (c == CHAR_NUL)
                    error_seen = 1'b1;
                else if (name_bytes != NAME_MAX)
                    name_bytes = name_bytes + 1'b1;
            end else if (c == CHAR_W_SEL) begin
                digit_target = SEL_W;
            end else if (c == CHAR_H_SEL) begin
                digit_target = SEL_H;
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (digit_target == SEL_W)
                    width_sum = shift_in_digit(width_sum, c);
                else if (digit_target == SEL_H)
                    height_sum = shift_in_digit(height_sum, c);
            end else if (c != CHAR_AMP && c != CHAR_EQ) begin
                error_seen = 1'b1;
            end
        end
        if (is_final) begin
            if (!mark_seen)
                r.status = ST_NO_MARK;
            else if (error_seen)
                r.status = ST_BAD_CHAR;
            else if (width_sum == '0 || width_sum > limit_w)
                r.status = ST_W_RANGE;
            else if (height_sum == '0 || height_sum > limit_h)
                r.status = ST_H_RANGE;
            else
                r.status = ST_OK;
            r.width_value  = width_sum;
            r.height_value = height_sum;
            r.name_length  = name_bytes;
            awaited_results.push_back(r);
            clear_parse();
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] result %0d: %s", $time, checked_total, msg);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            limit_w = MAX_W_RST;
            limit_h = MAX_H_RST;
            clear_parse();
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_MAX_WIDTH:  limit_w = i_cfg_wdata;
                    REG_MAX_HEIGHT: limit_h = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                take_request_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[RES_W-1:0]);
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, status %0d", got.status));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.width_value != want.width_value)
                        report_mismatch($sformatf("width %0d, expected %0d",
                                                  got.width_value, want.width_value));
                    if (got.height_value != want.height_value)
                        report_mismatch($sformatf("height %0d, expected %0d",
                                                  got.height_value, want.height_value));
                    if (got.name_length != want.name_length)
                        report_mismatch($sformatf("name length %0d, expected %0d",
                                                  got.name_length, want.name_length));
                    if (i_m_tdata[OUT_W-1:RES_W] != '0)
                        report_mismatch($sformatf("padding bits 'h%0h, expected zero",
                                                  i_m_tdata[OUT_W-1:RES_W]));
                end
                checked_total++;
            end
        end
        // Published with nonblocking updates so the stimulus side reads settled values.
        o_mismatches      <= mismatch_total;
        o_results_pending <= awaited_results.size();
        o_results_checked <= checked_total;
    end

endmodule

>>> sim/resize_query_parser_tb.sv
// Testbench top for the resize query parser: request stimulus, flow control and the verdict.
`timescale 1ns / 100ps

module resize_query_parser_tb;
    import rqp_pkg::*;

    // Watchdog limit on the run length; a correct run ends well within it.
    localparam int CYCLE_LIMIT      = 200_000;
    // Random request bytes sent under each limit setting.
    localparam int BYTES_PER_PHASE  = 265;
    localparam int PHASE_COUNT      = 7;

    typedef enum int {
        TAKE_ALL,
        TAKE_RANDOM,
        TAKE_PATTERN
    } t_take_mode;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [IDX_W-1:0]      i_cfg_index     = '0;
    logic [CFG_W-1:0]      i_cfg_wdata     = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [CHAR_W-1:0]     i_s_axis_tdata  = '0;
    logic                  i_s_axis_tlast  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_axis_tdata;

    int                    mismatches;
    int                    results_pending;
    int                    results_checked;

    // Stimulus bookkeeping.
    logic [CHAR_W-1:0]     request_text[$];
    int unsigned           bytes_offered   = 0;
    int                    burst_left      = 0;
    int unsigned           limit_w         = 4096;
    int unsigned           limit_h         = 4096;
    int                    settings_run    = 1;

    // Receiver flow control state, owned by the receiver process, and the watchdog's cycle count.
    t_take_mode            take_mode       = TAKE_ALL;
    int                    take_mode_left  = 0;
    logic [7:0]            take_mask       = 8'hFF;
    int unsigned           hold_left       = 0;
    int unsigned           hold_count      = 0;
    int unsigned           seen_bytes      = 0;
    int unsigned           cycle_count     = 0;

    resize_query_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    resize_query_parser_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_s_tvalid        (i_s_axis_tvalid),
        .i_s_tready        (o_s_axis_tready),
        .i_s_tdata         (i_s_axis_tdata),
        .i_s_tlast         (i_s_axis_tlast),
        .i_m_tvalid        (o_m_axis_tvalid),
        .i_m_tready        (i_m_axis_tready),
        .i_m_tdata         (o_m_axis_tdata),
        .o_mismatches      (mismatches),
        .o_results_pending (results_pending),
        .o_results_checked (results_checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, results_pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: switches between always ready, coin-flip ready and a rotating
    // mask. Twice during the run it holds off for a long stretch while the
    // sender keeps offering bytes, so that the held result blocks a final byte
    // and the slave side has to stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                seen_bytes++;
            if (take_mode_left == 0) begin
                take_mode      = t_take_mode'($urandom_range(2, 0));
                take_mode_left = $urandom_range(300, 40);
                take_mask      = 8'($urandom) | 8'h01;
            end
            take_mode_left--;
            take_mask = {take_mask[6:0], take_mask[7]};
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (hold_count < 2 && seen_bytes >= 300 + hold_count * 1200) begin
                hold_count++;
                hold_left = 250;
                i_m_axis_tready <= 1'b0;
            end else begin
                case (take_mode)
                    TAKE_ALL:    i_m_axis_tready <= 1'b1;
                    TAKE_RANDOM: i_m_axis_tready <= 1'($urandom_range(1, 0));
                    default:     i_m_axis_tready <= take_mask[0];
                endcase
            end
        end
    end

    // Offers one byte and returns after its transaction. The sender runs in
    // bursts; when a burst is used up a random gap may come first, with junk
    // on the data lines while tvalid is low.
    task automatic offer_byte(logic [CHAR_W-1:0] c, logic is_final);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 40)
                                                     : $urandom_range(12, 1);
            gap = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata  <= 8'($urandom);
                i_s_axis_tlast  <= 1'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= is_final;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_offered++;
    endtask

    task automatic send_request();
        for (int i = 0; i < request_text.size(); i++)
            offer_byte(request_text[i], i == request_text.size() - 1);
        request_text.delete();
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            request_text.push_back(s[i]);
        send_request();
    endtask

    // Stops offering and waits until every result has arrived, then lets the
    // pipeline run dry.
    task automatic settle(int tail);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Both limit registers are written back to back, width first.
    task automatic set_limits(int unsigned w, int unsigned h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MAX_WIDTH;
        i_cfg_wdata <= CFG_W'(w);
        @(posedge i_clk);
        i_cfg_index <= REG_MAX_HEIGHT;
        i_cfg_wdata <= CFG_W'(h);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_w = w;
        limit_h = h;
        settings_run++;
    endtask

    task automatic push_name_byte();
        logic [CHAR_W-1:0] c;
        c = $urandom_range(1, 0) ? 8'($urandom_range(122, 97)) : 8'($urandom_range(255, 1));
        if (c == CHAR_QMARK)
            c = CHAR_EQ;
        request_text.push_back(c);
    endtask

    // Appends a decimal value that sits near the interesting points of the
    // current limit: zero, one, the limit itself, just past it, a random value
    // up to just past it, or far beyond so the accumulator mostly saturates.
    task automatic push_dimension(int unsigned lim);
        int unsigned v;
        logic [CHAR_W-1:0] digits[$];
        case ($urandom_range(7, 0))
            0:       v = 0;
            1:       v = 1;
            2:       v = lim;
            3:       v = lim + 1;
            4:       v = $urandom_range(999999, 100000);
            default: v = $urandom_range(lim + 1, 1);
        endcase
        do begin
            digits.push_front(CHAR_W'(int'(CHAR_ZERO) + v % 10));
            v = v / 10;
        end while (v != 0);
        if ($urandom_range(9, 0) == 0)
            digits.push_front(CHAR_ZERO);
        foreach (digits[i])
            request_text.push_back(digits[i]);
    endtask

    // A well-formed request: name, mark, then width and height fields in
    // either order, with optional separators, sometimes a field left out and
    // sometimes a stray digit that arrives before any selector.
    task automatic build_query();
        int   name_len;
        logic height_first;
        logic pick_h;
        name_len = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 0);
        repeat (name_len) push_name_byte();
        request_text.push_back(CHAR_QMARK);
        if ($urandom_range(9, 0) == 0)
            request_text.push_back(CHAR_W'(int'(CHAR_ZERO) + $urandom_range(9, 0)));
        height_first = ($urandom_range(3, 0) == 0);
        for (int k = 0; k < 2; k++) begin
            if ($urandom_range(11, 0) == 0)
                continue;
            pick_h = height_first ^ k[0];
            if (k != 0 && $urandom_range(4, 0) != 0)
                request_text.push_back(CHAR_AMP);
            request_text.push_back(pick_h ? CHAR_H_SEL : CHAR_W_SEL);
            if ($urandom_range(4, 0) != 0)
                request_text.push_back(CHAR_EQ);
            push_dimension(pick_h ? limit_h : limit_w);
        end
    endtask

    // Breaks a request: an arbitrary byte overwritten, a zero byte or a
    // second mark slipped in, or the whole thing replaced by random noise.
    task automatic spoil_request();
        int n;
        n = request_text.size();
        case ($urandom_range(3, 0))
            0:       request_text[$urandom_range(n - 1, 0)] = 8'($urandom);
            1:       request_text.insert($urandom_range(n, 0), CHAR_NUL);
            2:       request_text.insert($urandom_range(n, 0), CHAR_QMARK);
            default: begin
                request_text.delete();
                repeat ($urandom_range(12, 1)) request_text.push_back(8'($urandom));
            end
        endcase
    endtask

    task automatic random_phase(int unsigned n_bytes);
        int unsigned stop_at;
        stop_at = bytes_offered + n_bytes;
        while (bytes_offered < stop_at) begin
            build_query();
            if ($urandom_range(5, 0) == 0)
                spoil_request();
            send_request();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset limits.
        send_text("a?9w=2&h=3");        // good request; stray digit dropped
        send_text("?");                 // empty query, width is zero
        request_text.push_back(8'hFF);  // top byte value, no mark at all
        send_request();
        request_text.push_back(CHAR_NUL);
        request_text.push_back(CHAR_QMARK);
        send_request();                 // zero byte freezes state, mark never seen
        send_text("??");                // second mark is a bad byte
        send_text("?w9999999");         // width saturates and is out of range
        send_text("?w1");               // height missing, out of range
        settle(4);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       set_limits(1, 65535);
                1:       set_limits(65535, 1);
                2:       set_limits(0, 9);     // a zero limit rejects every width
                3:       set_limits($urandom_range(200, 1), $urandom_range(200, 1));
                4:       set_limits(65535, 65535);
                5:       set_limits($urandom_range(65535, 1), $urandom_range(65535, 1));
                default: set_limits(4096, 4096);
            endcase
            random_phase(BYTES_PER_PHASE);
            settle(4);
        end
        settle(8);

        $display("Run covered %0d request bytes and %0d checked results", bytes_offered,
                 results_checked);
        $display("over %0d limit settings, with long receiver hold-offs and sender gaps.",
                 settings_run);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> resize_query_parser.f
+incdir+design
design/rqp_pkg.sv
design/rqp_in_stage.sv
design/rqp_parse.sv
design/rqp_out_stage.sv
design/resize_query_parser.sv
sim/resize_query_parser_checker.sv
sim/resize_query_parser_tb.sv
